FILE: sv/kil_pkg.sv
// ----------------------------------------------------------------------------
// kil_pkg
// Shared types and codes for the knot interval locator: command and status
// codes, the compare result and the sequencer handshake.
// ----------------------------------------------------------------------------
package kil_pkg;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_SEARCH = 2'd2;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_NONMONO = 3'd1;
   localparam logic [2:0] ST_FULL    = 3'd2;
   localparam logic [2:0] ST_FEW     = 3'd3;
   localparam logic [2:0] ST_RANGE   = 3'd4;

   typedef struct packed {
      logic less;
      logic equal;
   } kil_cmp_type;

   typedef struct packed {
      logic idle;
      logic done;
   } kil_seq_stat_type;

endpackage

FILE: sv/kil_knot_ram.sv
// ----------------------------------------------------------------------------
// kil_knot_ram
// Knot storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kil_knot_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/kil_cmp_unit.sv
// ----------------------------------------------------------------------------
// kil_cmp_unit
// Shared signed (two's complement) comparator used by the compare steps of the sequencer.
// ----------------------------------------------------------------------------
module kil_cmp_unit #(
   parameter int WIDTH = 32
) (
   input  logic [WIDTH-1:0]    lhs,
   input  logic [WIDTH-1:0]    rhs,
   output kil_pkg::kil_cmp_type result
);

   always_comb begin
      result.less  = $signed(lhs) < $signed(rhs);
      result.equal = lhs == rhs;
   end

endmodule

FILE: sv/kil_seq.sv
// ----------------------------------------------------------------------------
// kil_seq
// Command sequencer: table bookkeeping, cache test, range test, binary search
// and the duplicate/clamp fix-up, all through one comparator and one RAM read port.
// ----------------------------------------------------------------------------
module kil_seq #(
   parameter int MAX_KNOTS = 1024,
   parameter int KEY_BITS  = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [1:0]                     start_cmd,
   input  logic [KEY_BITS-1:0]            start_key,
   input  logic                           range_check,
   input  logic                           take,
   output kil_pkg::kil_seq_stat_type      stat,
   output logic [$clog2(MAX_KNOTS)-1:0]   res_interval,
   output logic [$clog2(MAX_KNOTS):0]     res_count,
   output logic [2:0]                     res_status
);

   localparam int IDX_W = $clog2(MAX_KNOTS);
   localparam int CNT_W = IDX_W + 1;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_CLO    = 4'd2;
   localparam logic [3:0] S_CHI    = 4'd3;
   localparam logic [3:0] S_RNG_LO = 4'd4;
   localparam logic [3:0] S_RNG_HI = 4'd5;
   localparam logic [3:0] S_BSC    = 4'd6;
   localparam logic [3:0] S_POST   = 4'd7;
   localparam logic [3:0] S_DUP0   = 4'd8;
   localparam logic [3:0] S_DUP1   = 4'd9;
   localparam logic [3:0] S_CLAMP  = 4'd10;
   localparam logic [3:0] S_DONE   = 4'd11;

   logic [3:0]          state_ff,    state_in;
   logic [1:0]          cmd_ff,      cmd_in;
   logic [KEY_BITS-1:0] opnd_ff,     opnd_in;
   logic [CNT_W-1:0]    total_ff,    total_in;
   logic [IDX_W-1:0]    cache_ff,    cache_in;
   logic [KEY_BITS-1:0] first_ff,    first_in;
   logic [KEY_BITS-1:0] last_ff,     last_in;
   logic [CNT_W-1:0]    lo_ff,       lo_in;
   logic [CNT_W-1:0]    hi_ff,       hi_in;
   logic [IDX_W-1:0]    mid_ff,      mid_in;
   logic [IDX_W-1:0]    pos_ff,      pos_in;
   logic [IDX_W-1:0]    interval_ff, interval_in;
   logic [2:0]          status_ff,   status_in;

   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [KEY_BITS-1:0] wr_data;
   logic [IDX_W-1:0]    rd_addr;
   logic [KEY_BITS-1:0] rd_data;
   logic [KEY_BITS-1:0] cmp_rhs;
   kil_pkg::kil_cmp_type cmp_res;

   logic [CNT_W-1:0]    cache_nxt;
   logic                go_right;
   logic [CNT_W-1:0]    bs_lo;
   logic [CNT_W-1:0]    bs_hi;
   logic [CNT_W:0]      bs_sum;
   logic [CNT_W-1:0]    lo_dec;
   logic [IDX_W-1:0]    post_pos;
   logic [CNT_W-1:0]    post_nxt;
   logic [CNT_W-1:0]    pos_nxt;
   logic [CNT_W-1:0]    total_m2;

   kil_knot_ram #(
      .DEPTH (MAX_KNOTS),
      .WIDTH (KEY_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   kil_cmp_unit #(
      .WIDTH (KEY_BITS)
   ) u_cmp (
      .lhs    (opnd_ff),
      .rhs    (cmp_rhs),
      .result (cmp_res)
   );

   assign cache_nxt = {1'b0, cache_ff} + CNT_W'(1);
   assign go_right  = !cmp_res.less && !cmp_res.equal;
   assign bs_lo     = go_right ? ({1'b0, mid_ff} + CNT_W'(1)) : lo_ff;
   assign bs_hi     = go_right ? hi_ff : {1'b0, mid_ff};
   assign bs_sum    = {1'b0, bs_lo} + {1'b0, bs_hi};
   assign lo_dec    = lo_ff - CNT_W'(1);
   assign post_pos  = (lo_ff == '0) ? '0 : lo_dec[IDX_W-1:0];
   assign post_nxt  = {1'b0, post_pos} + CNT_W'(1);
   assign pos_nxt   = {1'b0, pos_ff} + CNT_W'(1);
   assign total_m2  = total_ff - CNT_W'(2);

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      opnd_in     = opnd_ff;
      total_in    = total_ff;
      cache_in    = cache_ff;
      first_in    = first_ff;
      last_in     = last_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mid_in      = mid_ff;
      pos_in      = pos_ff;
      interval_in = interval_ff;
      status_in   = status_ff;
      wr_en       = 1'b0;
      wr_addr     = total_ff[IDX_W-1:0];
      wr_data     = opnd_ff;
      rd_addr     = mid_ff;
      cmp_rhs     = rd_data;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in   = start_cmd;
               opnd_in  = start_key;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            interval_in = '0;
            status_in   = kil_pkg::ST_OK;
            state_in    = S_DONE;
            unique case (cmd_ff)
               kil_pkg::CMD_CLEAR: begin
                  total_in = '0;
                  cache_in = '0;
               end
               kil_pkg::CMD_APPEND: begin
                  cmp_rhs = last_ff;
                  if (total_ff != '0 && cmp_res.less) begin
                     status_in = kil_pkg::ST_NONMONO;
                  end else if (total_ff == CNT_W'(MAX_KNOTS)) begin
                     status_in = kil_pkg::ST_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     last_in  = opnd_ff;
                     if (total_ff == '0) begin
                        first_in = opnd_ff;
                     end
                     total_in = total_ff + CNT_W'(1);
                  end
               end
               kil_pkg::CMD_SEARCH: begin
                  if (total_ff < CNT_W'(2)) begin
                     status_in = kil_pkg::ST_FEW;
                  end else if (cache_nxt < total_ff) begin
                     rd_addr  = cache_ff;
                     state_in = S_CLO;
                  end else begin
                     state_in = S_RNG_LO;
                  end
               end
               default: begin
               end
            endcase
         end
         S_CLO: begin
            if (cmp_res.less) begin
               state_in = S_RNG_LO;
            end else begin
               rd_addr  = cache_nxt[IDX_W-1:0];
               state_in = S_CHI;
            end
         end
         S_CHI: begin
            if (cmp_res.less || cmp_res.equal) begin
               interval_in = cache_ff;
               state_in    = S_DONE;
            end else begin
               state_in = S_RNG_LO;
            end
         end
         S_RNG_LO: begin
            cmp_rhs = first_ff;
            if (!range_check) begin
               lo_in    = '0;
               hi_in    = total_ff;
               mid_in   = total_ff[CNT_W-1:1];
               rd_addr  = total_ff[CNT_W-1:1];
               state_in = S_BSC;
            end else if (cmp_res.less) begin
               status_in = kil_pkg::ST_RANGE;
               state_in  = S_DONE;
            end else begin
               state_in = S_RNG_HI;
            end
         end
         S_RNG_HI: begin
            cmp_rhs = last_ff;
            if (go_right) begin
               status_in = kil_pkg::ST_RANGE;
               state_in  = S_DONE;
            end else begin
               lo_in    = '0;
               hi_in    = total_ff;
               mid_in   = total_ff[CNT_W-1:1];
               rd_addr  = total_ff[CNT_W-1:1];
               state_in = S_BSC;
            end
         end
         S_BSC: begin
            // narrow the lower-bound window and fetch the next probe at once
            lo_in = bs_lo;
            hi_in = bs_hi;
            if (bs_lo < bs_hi) begin
               mid_in  = bs_sum[IDX_W:1];
               rd_addr = bs_sum[IDX_W:1];
            end else begin
               state_in = S_POST;
            end
         end
         S_POST: begin
            pos_in = post_pos;
            if (post_nxt < total_ff) begin
               rd_addr  = post_pos;
               state_in = S_DUP0;
            end else begin
               state_in = S_CLAMP;
            end
         end
         S_DUP0: begin
            // hold knot[p] as the compare operand, fetch its right neighbor
            opnd_in  = rd_data;
            rd_addr  = pos_nxt[IDX_W-1:0];
            state_in = S_DUP1;
         end
         S_DUP1: begin
            if (cmp_res.equal) begin
               pos_in = pos_nxt[IDX_W-1:0];
            end
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            if (pos_nxt >= total_ff) begin
               cache_in    = total_m2[IDX_W-1:0];
               interval_in = total_m2[IDX_W-1:0];
            end else begin
               cache_in    = pos_ff;
               interval_in = pos_ff;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         total_ff <= '0;
         cache_ff <= '0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         cache_ff <= cache_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      opnd_ff     <= opnd_in;
      first_ff    <= first_in;
      last_ff     <= last_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      pos_ff      <= pos_in;
      interval_ff <= interval_in;
      status_ff   <= status_in;
   end

   always_comb begin
      stat.idle = state_ff == S_IDLE;
      stat.done = state_ff == S_DONE;
   end

   assign res_interval = interval_ff;
   assign res_count    = total_ff;
   assign res_status   = status_ff;

endmodule

FILE: sv/knot_interval_locator.sv
// ----------------------------------------------------------------------------
// knot_interval_locator
// Sorted knot table with clear, append and cached interval search commands.
//
//   channel  direction  ports                                   transfer when
//   req      in         req_command, req_key                    req_valid & req_ready
//   rsp      out        rsp_interval, rsp_knot_count, rsp_status rsp_valid & rsp_ready
//   csr      in         csr_wr_data (range check enable)        csr_wr_en
//
// Clear, append, searches on fewer than two knots and the unused command are
// settled in the decode state. A search that hits the cached interval compares
// the two cached knots, an out-of-range search the first and last knot, and a
// miss runs a binary search, one probe per cycle on the RAM read port.
// One command is in flight at a time; the next is taken while a result waits.
// Reset is synchronous and empties the table; no clearing pass is needed.
// ----------------------------------------------------------------------------
module knot_interval_locator #(
   parameter int MAX_KNOTS = 1024,
   parameter int KEY_BITS  = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_command,
   input  logic signed [KEY_BITS-1:0]         req_key,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [$clog2(MAX_KNOTS)-1:0]       rsp_interval,
   output logic [$clog2(MAX_KNOTS):0]         rsp_knot_count,
   output logic [2:0]                         rsp_status,
   input  logic                               csr_wr_en,
   input  logic                               csr_wr_data
);

   localparam int IDX_W = $clog2(MAX_KNOTS);
   localparam int CNT_W = IDX_W + 1;

   logic                      rng_chk_ff,  rng_chk_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]          interval_ff;
   logic [CNT_W-1:0]          count_ff;
   logic [2:0]                status_ff;

   kil_pkg::kil_seq_stat_type seq_stat;
   logic                      take;
   logic [IDX_W-1:0]          res_interval;
   logic [CNT_W-1:0]          res_count;
   logic [2:0]                res_status;

   kil_seq #(
      .MAX_KNOTS (MAX_KNOTS),
      .KEY_BITS  (KEY_BITS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .start        (req_valid && seq_stat.idle),
      .start_cmd    (req_command),
      .start_key    (req_key),
      .range_check  (rng_chk_ff),
      .take         (take),
      .stat         (seq_stat),
      .res_interval (res_interval),
      .res_count    (res_count),
      .res_status   (res_status)
   );

   assign req_ready    = seq_stat.idle;
   // advance the finished result into the output register once it is free
   assign take         = seq_stat.done && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = take || (rsp_valid_ff && !rsp_ready);
   assign rng_chk_in   = csr_wr_en ? csr_wr_data : rng_chk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rng_chk_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rng_chk_ff   <= rng_chk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         interval_ff <= res_interval;
         count_ff    <= res_count;
         status_ff   <= res_status;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_interval   = interval_ff;
   assign rsp_knot_count = count_ff;
   assign rsp_status     = status_ff;

endmodule

FILE: bench/knot_locator_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// knot_locator_monitor
// Watches the request, result and register ports of the knot interval
// locator, keeps its own copy of the knot table and the cached interval,
// predicts the answer to every accepted command and compares each result
// transfer field by field with the oldest pending answer.
// ----------------------------------------------------------------------------
module knot_locator_monitor #(
   parameter int MAX_KNOTS = 1024,
   parameter int KEY_BITS  = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [1:0]                        req_command,
   input  logic signed [KEY_BITS-1:0]        req_key,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [$clog2(MAX_KNOTS)-1:0]      rsp_interval,
   input  logic [$clog2(MAX_KNOTS):0]        rsp_knot_count,
   input  logic [2:0]                        rsp_status,
   input  logic                              csr_wr_en,
   input  logic                              csr_wr_data,
   output int                                mismatch_count,
   output int                                answers_pending,
   output int                                answers_checked
);

   localparam int IDX_W = $clog2(MAX_KNOTS);

   typedef struct packed {
      logic [IDX_W-1:0] interval;
      logic [IDX_W:0]   knot_count;
      logic [2:0]       status;
   } answer_type;

   logic signed [KEY_BITS-1:0] knot_mirror [MAX_KNOTS];
   int                         knot_fill;
   int                         hot_interval;
   logic                       range_check;
   answer_type                 expected_answers [$];

   task automatic locate_command(input logic [1:0] cmd,
                                 input logic signed [KEY_BITS-1:0] key,
                                 output answer_type ans);
      int   lo;
      int   hi;
      int   mid;
      int   p;
      int   c;
      logic hit;
      ans = '0;
      ans.status = kil_pkg::ST_OK;
      case (cmd)
         kil_pkg::CMD_CLEAR: begin
            knot_fill = 0;
            hot_interval = 0;
         end
         kil_pkg::CMD_APPEND: begin
            // monotonicity is tested before fullness
            if (knot_fill > 0 && key < knot_mirror[knot_fill-1]) begin
               ans.status = kil_pkg::ST_NONMONO;
            end else if (knot_fill >= MAX_KNOTS) begin
               ans.status = kil_pkg::ST_FULL;
            end else begin
               knot_mirror[knot_fill] = key;
               knot_fill++;
            end
         end
         kil_pkg::CMD_SEARCH: begin
            if (knot_fill < 2) begin
               ans.status = kil_pkg::ST_FEW;
            end else begin
               c = hot_interval;
               hit = (c + 1 < knot_fill) && knot_mirror[c] <= key &&
                     key <= knot_mirror[c+1];
               if (hit) begin
                  ans.interval = c[IDX_W-1:0];
               end else if (range_check &&
                            (key < knot_mirror[0] || key > knot_mirror[knot_fill-1])) begin
                  ans.status = kil_pkg::ST_RANGE;
               end else begin
                  lo = 0;
                  hi = knot_fill;
                  while (lo < hi) begin
                     mid = lo + (hi - lo) / 2;
                     if (knot_mirror[mid] < key) lo = mid + 1;
                     else hi = mid;
                  end
                  // step back, skip a duplicated knot, clamp to the last interval
                  p = lo;
                  if (p > 0) p--;
                  if (p + 1 < knot_fill && knot_mirror[p] == knot_mirror[p+1]) p++;
                  if (p + 1 >= knot_fill) p = knot_fill - 2;
                  hot_interval = p;
                  ans.interval = p[IDX_W-1:0];
               end
            end
         end
         default: ;
      endcase
      ans.knot_count = knot_fill[IDX_W:0];
   endtask

   always @(posedge clock) begin : watch_channels
      answer_type want;
      if (reset) begin
         knot_fill = 0;
         hot_interval = 0;
         range_check = 1'b0;
         expected_answers.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            answers_checked++;
            if (expected_answers.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected result: interval %0d count %0d status %0d",
                           rsp_interval, rsp_knot_count, rsp_status);
               mismatch_count++;
            end else begin
               want = expected_answers.pop_front();
               if (rsp_interval !== want.interval || rsp_knot_count !== want.knot_count ||
                   rsp_status !== want.status) begin
                  if (mismatch_count < 10) begin
                     $display("result %0d: expected interval %0d count %0d status %0d",
                              answers_checked, want.interval, want.knot_count, want.status);
                     $display("   got interval %0d count %0d status %0d",
                              rsp_interval, rsp_knot_count, rsp_status);
                  end
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            locate_command(req_command, req_key, want);
            expected_answers.push_back(want);
         end
         if (csr_wr_en) range_check = csr_wr_data;
      end
      answers_pending = expected_answers.size();
   end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the knot interval locator: a directed pass over empty, short
// and duplicated tables, then random table builds with searches, one build
// to a full table, and both settings of range checking. The monitor predicts
// and checks every result; this module drives the ports and gives the verdict.
// ----------------------------------------------------------------------------
module tb;

   localparam int MAX_KNOTS    = 1024;
   localparam int KEY_BITS     = 32;
   localparam int IDX_W        = $clog2(MAX_KNOTS);
   localparam int CYCLE_LIMIT  = 800000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 200;
   localparam int SMALL_BUDGET = 60;
   localparam int FULL_SEARCHES = 20;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [1:0]                 req_command;
   logic signed [KEY_BITS-1:0] req_key;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [IDX_W-1:0]           rsp_interval;
   logic [IDX_W:0]             rsp_knot_count;
   logic [2:0]                 rsp_status;
   logic                       csr_wr_en;
   logic                       csr_wr_data;

   int   mismatch_count;
   int   answers_pending;
   int   answers_checked;
   int   cycle_count;
   int   sent_total;
   int   sent_appends;
   int   sent_searches;
   int   peak_fill;
   logic no_idle;
   logic hold_request;

   // keys of the knots the block should hold, used to aim search keys
   logic signed [31:0] knot_keys [$];
   logic signed [31:0] last_search_key;

   knot_interval_locator #(
      .MAX_KNOTS (MAX_KNOTS),
      .KEY_BITS  (KEY_BITS)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_key        (req_key),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_interval   (rsp_interval),
      .rsp_knot_count (rsp_knot_count),
      .rsp_status     (rsp_status),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   knot_locator_monitor #(
      .MAX_KNOTS (MAX_KNOTS),
      .KEY_BITS  (KEY_BITS)
   ) u_monitor (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_key         (req_key),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_interval    (rsp_interval),
      .rsp_knot_count  (rsp_knot_count),
      .rsp_status      (rsp_status),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .mismatch_count  (mismatch_count),
      .answers_pending (answers_pending),
      .answers_checked (answers_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
   end

   // result side: random back-pressure, one long hold-off on request
   initial begin : drive_rsp_ready
      bit hold_done;
      hold_done = 1'b0;
      rsp_ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end
         rsp_ready <= no_idle || ($urandom_range(0, 99) >= 33);
      end
   end

   function automatic logic signed [31:0] clamp_key(longint v);
      if (v > longint'(KEY_MAX)) return KEY_MAX;
      if (v < longint'(KEY_MIN)) return KEY_MIN;
      return v[31:0];
   endfunction

   function automatic longint random_between(longint lo, longint hi);
      return lo + longint'({32'd0, $urandom}) % (hi - lo + 1);
   endfunction

   function automatic longint knot_gap(int scale_bits);
      if ($urandom_range(0, 99) < 18) return 0;
      return longint'({32'd0, $urandom}) % (longint'(1) << scale_bits) + 1;
   endfunction

   function automatic logic signed [31:0] pick_search_key();
      int     n;
      int     r;
      int     d;
      longint lo;
      longint hi;
      n = knot_keys.size();
      r = $urandom_range(0, 99);
      if (n == 0 || r >= 94) return $urandom;
      lo = knot_keys[0];
      hi = knot_keys[n-1];
      if (r < 35) return knot_keys[$urandom_range(0, n - 1)];
      if (r < 65) return clamp_key(random_between(lo, hi));
      if (r < 80) begin
         d = $urandom_range(0, 2000);
         d = d - 1000;
         return clamp_key(longint'(last_search_key) + d);
      end
      if ($urandom_range(0, 1) == 0 && lo > longint'(KEY_MIN))
         return clamp_key(random_between(longint'(KEY_MIN), lo - 1));
      if (hi < longint'(KEY_MAX))
         return clamp_key(random_between(hi + 1, longint'(KEY_MAX)));
      return $urandom;
   endfunction

   // present one command and hold it until the transfer; returns at a falling edge
   task automatic send(input logic [1:0] cmd, input logic signed [31:0] key);
      while (!no_idle && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_key     <= key;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      case (cmd)
         kil_pkg::CMD_CLEAR: knot_keys.delete();
         kil_pkg::CMD_APPEND: begin
            sent_appends++;
            if (knot_keys.size() < MAX_KNOTS &&
                (knot_keys.size() == 0 || key >= knot_keys[$]))
               knot_keys.push_back(key);
         end
         kil_pkg::CMD_SEARCH: begin
            sent_searches++;
            last_search_key = key;
         end
         default: ;
      endcase
      if (cmd != CMD_UNUSED) sent_total++;
      if (knot_keys.size() > peak_fill) peak_fill = knot_keys.size();
   endtask

   task automatic send_search();
      send(kil_pkg::CMD_SEARCH, pick_search_key());
   endtask

   task automatic send_next_knot(int scale_bits);
      if (knot_keys.size() == 0) send(kil_pkg::CMD_APPEND, $urandom);
      else send(kil_pkg::CMD_APPEND,
                clamp_key(longint'(knot_keys[$]) + knot_gap(scale_bits)));
   endtask

   task automatic send_backward_knot();
      if (knot_keys.size() > 0 && knot_keys[$] > KEY_MIN)
         send(kil_pkg::CMD_APPEND, clamp_key(random_between(longint'(KEY_MIN),
                                                            longint'(knot_keys[$]) - 1)));
      else
         send(kil_pkg::CMD_APPEND, $urandom);
   endtask

   // drop valid and wait for every pending result plus the block's latency
   task automatic settle();
      req_valid <= 1'b0;
      while (answers_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_range_check(input logic value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      @(negedge clock);
   endtask

   task automatic build_and_search(int n_knots, int n_searches);
      int scale_bits;
      int r;
      scale_bits = $urandom_range(0, 28);
      send(kil_pkg::CMD_CLEAR, $urandom);
      r = $urandom_range(0, 99);
      if (n_knots > 0) begin
         if (r < 30) send(kil_pkg::CMD_APPEND, KEY_MIN);
         else if (r < 60) send(kil_pkg::CMD_APPEND, $urandom);
         else send(kil_pkg::CMD_APPEND, clamp_key(random_between(-(1 << 20), 1 << 20)));
      end
      for (int i = 1; i < n_knots; i++) begin
         r = $urandom_range(0, 99);
         if (r < 5) send_backward_knot();
         else if (r < 8) send(CMD_UNUSED, $urandom);
         else if (r < 16) send_search();
         send_next_knot(scale_bits);
      end
      for (int j = 0; j < n_searches; j++) begin
         r = $urandom_range(0, 99);
         if (r < 4) send(CMD_UNUSED, $urandom);
         else if (r < 9) send_next_knot(scale_bits);
         else if (r < 12) send_backward_knot();
         else send_search();
      end
   endtask

   task automatic fill_table();
      int r;
      send(kil_pkg::CMD_CLEAR, 32'sd0);
      send(kil_pkg::CMD_APPEND, KEY_MIN);
      while (knot_keys.size() < MAX_KNOTS) begin
         if (knot_keys.size() == 10) hold_request <= 1'b1;
         no_idle <= (knot_keys.size() >= 300 && knot_keys.size() < 600);
         r = $urandom_range(0, 99);
         if (r < 2) send_search();
         else if (r < 4) send_backward_knot();
         if (knot_keys.size() == MAX_KNOTS - 1) send(kil_pkg::CMD_APPEND, KEY_MAX);
         else send_next_knot(22);
      end
      no_idle <= 1'b0;
      // full table: a forward append is refused, a backward one fails monotonicity first
      send(kil_pkg::CMD_APPEND, KEY_MAX);
      send(kil_pkg::CMD_APPEND, KEY_MIN);
      send(kil_pkg::CMD_APPEND, knot_keys[$]);
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_command     = kil_pkg::CMD_CLEAR;
      req_key         = '0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = 1'b0;
      no_idle         = 1'b0;
      hold_request    = 1'b0;
      sent_total      = 0;
      sent_appends    = 0;
      sent_searches   = 0;
      peak_fill       = 0;
      last_search_key = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty and one-knot tables, duplicates, extremes, unused command
      write_range_check(1'b0);
      send(kil_pkg::CMD_SEARCH, 32'sd0);
      send(kil_pkg::CMD_APPEND, KEY_MIN);
      send(kil_pkg::CMD_SEARCH, KEY_MIN);
      send(kil_pkg::CMD_APPEND, KEY_MIN);
      send(kil_pkg::CMD_APPEND, -32'sd65536);
      send(kil_pkg::CMD_APPEND, 32'sd0);
      send(kil_pkg::CMD_APPEND, 32'sd0);
      send(kil_pkg::CMD_APPEND, KEY_MAX);
      send(kil_pkg::CMD_APPEND, 32'sd65536);
      send(CMD_UNUSED, 32'sd0);
      send(kil_pkg::CMD_SEARCH, KEY_MIN);
      send(kil_pkg::CMD_SEARCH, KEY_MIN);
      send(kil_pkg::CMD_SEARCH, 32'sd0);
      send(kil_pkg::CMD_SEARCH, 32'sd1);
      send(kil_pkg::CMD_SEARCH, KEY_MAX);

      // directed: range checking on, then off again
      write_range_check(1'b1);
      send(kil_pkg::CMD_CLEAR, KEY_MAX);
      send(kil_pkg::CMD_APPEND, -32'sd100);
      send(kil_pkg::CMD_APPEND, 32'sd100);
      send(kil_pkg::CMD_APPEND, 32'sd100);
      send(kil_pkg::CMD_APPEND, 32'sd200);
      send(kil_pkg::CMD_SEARCH, -32'sd200);
      send(kil_pkg::CMD_SEARCH, 32'sd300);
      send(kil_pkg::CMD_SEARCH, 32'sd100);
      send(kil_pkg::CMD_SEARCH, 32'sd150);
      send(kil_pkg::CMD_SEARCH, 32'sd200);
      send(kil_pkg::CMD_SEARCH, KEY_MIN);
      write_range_check(1'b0);
      send(kil_pkg::CMD_SEARCH, KEY_MIN);
      send(kil_pkg::CMD_SEARCH, KEY_MAX);

      // random tables of mostly small size, alternating range checking
      for (int s = 0; sent_total < SMALL_BUDGET; s++) begin
         write_range_check(s[0]);
         case ($urandom_range(0, 19))
            0, 1:    build_and_search($urandom_range(0, 1), $urandom_range(2, 6));
            2, 3, 4: build_and_search($urandom_range(25, 120), $urandom_range(10, 30));
            default: build_and_search($urandom_range(2, 24), $urandom_range(4, 24));
         endcase
      end

      // one table filled to capacity, searched with both settings
      write_range_check(1'b1);
      fill_table();
      for (int j = 0; j < FULL_SEARCHES; j++) send_search();
      write_range_check(1'b0);
      send(kil_pkg::CMD_SEARCH, KEY_MIN);
      send(kil_pkg::CMD_SEARCH, KEY_MAX);
      for (int j = 0; j < FULL_SEARCHES; j++) send_search();

      settle();
      $display("Sent %0d commands (%0d appends, %0d searches), table filled up to %0d knots,",
               sent_total, sent_appends, sent_searches, peak_fill);
      $display("range check on and off; %0d results checked, %0d mismatches.",
               answers_checked, mismatch_count);
      if (mismatch_count == 0 && answers_pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: knot_interval_locator.f
sv/kil_pkg.sv
sv/kil_knot_ram.sv
sv/kil_cmp_unit.sv
sv/kil_seq.sv
sv/knot_interval_locator.sv
bench/knot_locator_monitor.sv
bench/tb.sv
